// ===== hw/rtl/slcan_pkg.sv =====
// SLCAN line parser package: character codes, line kind encoding, result record
// and hex/type decode helpers. No dependencies; used by all slcan modules.
`default_nettype none

package slcan_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_STD  = 8'h74;  // t
  localparam logic [7:0] CHAR_EXT  = 8'h54;  // T
  localparam logic [7:0] CHAR_EXTX = 8'h78;  // x
  localparam logic [7:0] CHAR_SRTR = 8'h72;  // r
  localparam logic [7:0] CHAR_ERTR = 8'h52;  // R
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;

  localparam logic [5:0] COUNT_MAX    = 6'd63;
  localparam logic [2:0] TAIL_MAX     = 3'd5;
  localparam logic [2:0] STAMP_DIGITS = 3'd4;
  localparam logic [3:0] ID_STD_DIGITS = 4'd3;
  localparam logic [3:0] ID_EXT_DIGITS = 4'd8;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_STD     = 3'd1,
    KIND_EXT     = 3'd2,
    KIND_STD_RTR = 3'd3,
    KIND_EXT_RTR = 3'd4,
    KIND_BAD     = 3'd5
  } kind_t;

  typedef struct packed {
    logic        status;
    logic [31:0] can_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  length_code;
    logic [63:0] payload;
    logic [15:0] stamp_ms;
    logic        has_stamp;
  } res_t;

  typedef struct packed {
    logic emit;
    logic busy;
  } line_ctl_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  function automatic kind_t kind_of(input logic [7:0] c);
    kind_t k;
    k = KIND_BAD;
    if (c == CHAR_STD) k = KIND_STD;
    else if (c == CHAR_EXT || c == CHAR_EXTX) k = KIND_EXT;
    else if (c == CHAR_SRTR) k = KIND_STD_RTR;
    else if (c == CHAR_ERTR) k = KIND_EXT_RTR;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slcan_line.sv =====
// Line state and field accumulators; decides the result of a line at CR/LF.
// Depends on slcan_pkg.
`default_nettype none

module slcan_line (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic [7:0]       rx_char,
  input  wire logic             keep_remote,
  output slcan_pkg::line_ctl_t  ctl,
  output slcan_pkg::res_t       res
);

  logic [5:0]          cc, cc_next;
  slcan_pkg::kind_t    kind, kind_next;
  logic [31:0]         id_acc, id_acc_next;
  logic [3:0]          len_dig, len_dig_next;
  logic                len_bad, len_bad_next;
  logic [63:0]         data_acc, data_acc_next;
  logic [2:0]          tail, tail_next;
  logic [15:0]         stamp_acc, stamp_acc_next;
  logic                stopped, stopped_next;

  logic                is_term, ext, remote, reject, has_stamp;
  logic [3:0]          idlen;
  logic [4:0]          dlen;
  logic [4:0]          hx;
  logic                nonhex, stop_eff;
  logic [5:0]          q;
  logic [5:0]          boff;
  logic [6:0]          min_len;

  assign is_term = (rx_char == slcan_pkg::CHAR_CR) || (rx_char == slcan_pkg::CHAR_LF);
  assign ext     = (kind == slcan_pkg::KIND_EXT) || (kind == slcan_pkg::KIND_EXT_RTR);
  assign remote  = (kind == slcan_pkg::KIND_STD_RTR) || (kind == slcan_pkg::KIND_EXT_RTR);
  assign idlen   = ext ? slcan_pkg::ID_EXT_DIGITS : slcan_pkg::ID_STD_DIGITS;
  assign dlen    = (remote || len_bad) ? 5'd0 : {len_dig, 1'b0};
  assign hx      = slcan_pkg::hex_nib(rx_char);
  assign nonhex  = hx[4];
  assign q       = 6'(cc - 6'(idlen) - 6'd2);
  assign boff    = {q[3:1], 3'b000};
  assign min_len = 7'(idlen) + 7'd2;

  assign reject = (kind == slcan_pkg::KIND_BAD) || (kind == slcan_pkg::KIND_NONE)
                || ({1'b0, cc} < min_len) || len_bad
                || (!remote && ({1'b0, cc} < (min_len + 7'(dlen))));
  assign has_stamp = (tail == slcan_pkg::STAMP_DIGITS);

  assign ctl.busy = (cc != 6'd0);
  assign ctl.emit = is_term && ctl.busy && (reject || !remote || keep_remote);

  always_comb begin
    res = '0;
    if (reject) begin
      res.status = 1'b1;
    end else begin
      res.can_id      = id_acc;
      res.is_extended = ext;
      res.is_remote   = remote;
      res.length_code = len_dig;
      res.payload     = remote ? 64'd0 : data_acc;
      res.stamp_ms    = has_stamp ? stamp_acc : 16'd0;
      res.has_stamp   = has_stamp;
    end
  end

  always_comb begin
    cc_next        = cc;
    kind_next      = kind;
    id_acc_next    = id_acc;
    len_dig_next   = len_dig;
    len_bad_next   = len_bad;
    data_acc_next  = data_acc;
    tail_next      = tail;
    stamp_acc_next = stamp_acc;
    stopped_next   = stopped;
    stop_eff       = stopped;
    if (adv) begin
      if (is_term) begin
        if (cc != 6'd0) begin
          cc_next        = '0;
          kind_next      = slcan_pkg::KIND_NONE;
          id_acc_next    = '0;
          len_dig_next   = '0;
          len_bad_next   = 1'b0;
          data_acc_next  = '0;
          tail_next      = '0;
          stamp_acc_next = '0;
          stopped_next   = 1'b0;
        end
      end else begin
        if (cc != slcan_pkg::COUNT_MAX) cc_next = 6'(cc + 6'd1);
        if (cc == 6'd0) begin
          kind_next    = slcan_pkg::kind_of(rx_char);
          stopped_next = 1'b0;
        end else if (kind != slcan_pkg::KIND_BAD && kind != slcan_pkg::KIND_NONE) begin
          if (cc <= 6'(idlen)) begin
            stopped_next = stopped || nonhex;
            if (!(stopped || nonhex)) id_acc_next = {id_acc[27:0], hx[3:0]};
          end else if (cc == 6'(idlen) + 6'd1) begin
            if (rx_char inside {[slcan_pkg::CHAR_ZERO : slcan_pkg::CHAR_EIGHT]}) begin
              len_dig_next = rx_char[3:0];
            end else begin
              len_dig_next = 4'd0;
              len_bad_next = 1'b1;
            end
          end else if ({1'b0, q} < 7'(dlen)) begin
            stop_eff     = q[0] ? stopped : 1'b0;
            stopped_next = stop_eff || nonhex;
            if (!(stop_eff || nonhex))
              data_acc_next[boff +: 8] = {data_acc[boff +: 4], hx[3:0]};
          end else begin
            stop_eff     = (tail == 3'd0) ? 1'b0 : stopped;
            stopped_next = stop_eff;
            if (tail < slcan_pkg::STAMP_DIGITS) begin
              stopped_next = stop_eff || nonhex;
              if (!(stop_eff || nonhex)) stamp_acc_next = {stamp_acc[11:0], hx[3:0]};
            end
            if (tail < slcan_pkg::TAIL_MAX) tail_next = 3'(tail + 3'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc        <= '0;
      kind      <= slcan_pkg::KIND_NONE;
      id_acc    <= '0;
      len_dig   <= '0;
      len_bad   <= 1'b0;
      data_acc  <= '0;
      tail      <= '0;
      stamp_acc <= '0;
      stopped   <= 1'b0;
    end else begin
      cc        <= cc_next;
      kind      <= kind_next;
      id_acc    <= id_acc_next;
      len_dig   <= len_dig_next;
      len_bad   <= len_bad_next;
      data_acc  <= data_acc_next;
      tail      <= tail_next;
      stamp_acc <= stamp_acc_next;
      stopped   <= stopped_next;
    end
  end

  chk_tail_sat: assert property (@(posedge clk) disable iff (rst)
    tail <= slcan_pkg::TAIL_MAX)
    else $error("tail count past saturation");

  chk_len_range: assert property (@(posedge clk) disable iff (rst)
    len_dig <= 4'd8)
    else $error("length digit out of range");

  chk_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && is_term && ctl.busy) |=> (cc == 6'd0 && kind == slcan_pkg::KIND_NONE))
    else $error("line state not cleared at end of line");

endmodule

`default_nettype wire

// ===== hw/rtl/slcan_frame_reg.sv =====
// Result register: holds one parsed frame until the downstream side takes it.
// Depends on slcan_pkg.
`default_nettype none

module slcan_frame_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire slcan_pkg::res_t res_in,
  output logic                 free,
  output logic                 frame_valid,
  input  wire logic            frame_ready,
  output slcan_pkg::res_t      res_q
);

  assign free = !frame_valid || frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (load) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res_in;
  end

  chk_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("frame overwritten before it was taken");

  chk_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> frame_valid)
    else $error("loaded frame not presented");

  chk_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && res_q.status) |-> (res_q.can_id == 32'd0 && res_q.payload == 64'd0
                                       && res_q.has_stamp == 1'b0))
    else $error("rejected line carries field data");

endmodule

`default_nettype wire

// ===== hw/rtl/slcan_line_frame_parser_core.sv =====
// SLCAN ASCII line parser, top level. Takes one character per beat on rx and returns
// one frame beat per non-empty line (none for a dropped remote line) on frame.
// Depends on slcan_pkg, slcan_line and slcan_frame_reg.
//
// Accepts one character every cycle while rx_ready is high. A character is held in an
// input register and applied to the line accumulators when it advances; the frame
// for a CR or LF is loaded into the result register at that same edge, so frame_valid
// rises at the edge on which the line end leaves the input register.
// rx_ready drops only while a line end that yields a frame waits behind a frame not
// yet taken.
// keep_remote (written through keep_remote_we/keep_remote_wdata, reset 0) selects
// whether parsed remote frames are delivered.
`default_nettype none

module slcan_line_frame_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        keep_remote_we,
  input  wire logic        keep_remote_wdata,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             frame_valid,
  input  wire logic        frame_ready,
  output logic             status,
  output logic [31:0]      can_id,
  output logic             is_extended,
  output logic             is_remote,
  output logic [3:0]       length_code,
  output logic [63:0]      payload,
  output logic [15:0]      stamp_ms,
  output logic             has_stamp
);

  logic                 keep_remote;
  logic                 in_full;
  logic [7:0]           in_byte;
  logic                 advance;
  logic                 free;
  slcan_pkg::line_ctl_t ctl;
  slcan_pkg::res_t      res_c;
  slcan_pkg::res_t      res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_remote <= 1'b0;
    end else if (keep_remote_we) begin
      keep_remote <= keep_remote_wdata;
    end
  end

  assign advance  = in_full && (!ctl.emit || free);
  assign rx_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) in_byte <= rx_byte;
  end

  slcan_line u_line (
    .clk         (clk),
    .rst         (rst),
    .adv         (advance),
    .rx_char     (in_byte),
    .keep_remote (keep_remote),
    .ctl         (ctl),
    .res         (res_c)
  );

  slcan_frame_reg u_frame (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && ctl.emit),
    .res_in      (res_c),
    .free        (free),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .res_q       (res_q)
  );

  assign status      = res_q.status;
  assign can_id      = res_q.can_id;
  assign is_extended = res_q.is_extended;
  assign is_remote   = res_q.is_remote;
  assign length_code = res_q.length_code;
  assign payload     = res_q.payload;
  assign stamp_ms    = res_q.stamp_ms;
  assign has_stamp   = res_q.has_stamp;

  chk_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (in_full && ctl.emit && frame_valid && !frame_ready))
    else $error("input stalled without a blocked frame");

  chk_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_byte)))
    else $error("held character lost");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for slcan_line_frame_parser_core: drives ASCII bytes, predicts each
// frame beat in-line and checks it field by field. Depends on slcan_pkg.
module tb;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        keep_remote_we = 1'b0;
  logic        keep_remote_wdata = 1'b0;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_valid;
  logic        frame_ready = 1'b0;
  logic        status;
  logic [31:0] can_id;
  logic        is_extended;
  logic        is_remote;
  logic [3:0]  length_code;
  logic [63:0] payload;
  logic [15:0] stamp_ms;
  logic        has_stamp;

  slcan_line_frame_parser_core dut (
    .clk(clk),
    .rst(rst),
    .keep_remote_we(keep_remote_we),
    .keep_remote_wdata(keep_remote_wdata),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .status(status),
    .can_id(can_id),
    .is_extended(is_extended),
    .is_remote(is_remote),
    .length_code(length_code),
    .payload(payload),
    .stamp_ms(stamp_ms),
    .has_stamp(has_stamp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0]        pending[$];
  slcan_pkg::res_t   frames_due[$];
  int unsigned       queued_total = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  bit                hold_want = 1'b0;
  int unsigned       errors = 0;

  // line state of the predictor
  logic              keep_remote_cfg;
  logic [5:0]        ln_count;
  slcan_pkg::kind_t  ln_kind;
  logic [31:0]       ln_id;
  logic [3:0]        ln_dlc;
  logic              ln_dlc_bad;
  logic [63:0]       ln_data;
  logic [2:0]        ln_tail;
  logic [15:0]       ln_stamp;
  logic              ln_stop;

  function automatic void start_line();
    ln_count = '0;
    ln_kind = slcan_pkg::KIND_NONE;
    ln_id = '0;
    ln_dlc = '0;
    ln_dlc_bad = 1'b0;
    ln_data = '0;
    ln_tail = '0;
    ln_stamp = '0;
    ln_stop = 1'b0;
  endfunction

  function automatic int unsigned nibble_of(input logic [7:0] c);
    if (c >= 8'("0") && c <= 8'("9")) return 32'(c - 8'("0"));
    if (c >= 8'("a") && c <= 8'("f")) return 32'(c - 8'("a")) + 10;
    if (c >= 8'("A") && c <= 8'("F")) return 32'(c - 8'("A")) + 10;
    return 16;
  endfunction

  function automatic int unsigned run_digit(input logic [7:0] c);
    int unsigned d;
    d = nibble_of(c);
    if (ln_stop || d > 15) begin
      ln_stop = 1'b1;
      d = 16;
    end
    return d;
  endfunction

  task automatic parse_char(input logic [7:0] c);
    int unsigned pos, idn, q, dn, d, sh;
    logic ext, rtr, rej;
    slcan_pkg::res_t f;
    ext = (ln_kind == slcan_pkg::KIND_EXT || ln_kind == slcan_pkg::KIND_EXT_RTR);
    rtr = (ln_kind == slcan_pkg::KIND_STD_RTR || ln_kind == slcan_pkg::KIND_EXT_RTR);
    idn = ext ? 8 : 3;
    dn = (rtr || ln_dlc_bad) ? 0 : 2 * 32'(ln_dlc);
    if (c == slcan_pkg::CHAR_CR || c == slcan_pkg::CHAR_LF) begin
      if (ln_count != 0) begin
        rej = (ln_kind == slcan_pkg::KIND_BAD || ln_kind == slcan_pkg::KIND_NONE) ||
              32'(ln_count) < idn + 2 || ln_dlc_bad ||
              (!rtr && 32'(ln_count) < idn + 2 + dn);
        f = '0;
        if (rej) begin
          f.status = 1'b1;
          frames_due.push_back(f);
        end else if (!rtr || keep_remote_cfg) begin
          f.can_id = ln_id;
          f.is_extended = ext;
          f.is_remote = rtr;
          f.length_code = ln_dlc;
          f.payload = rtr ? 64'd0 : ln_data;
          if (ln_tail == slcan_pkg::STAMP_DIGITS) begin
            f.stamp_ms = ln_stamp;
            f.has_stamp = 1'b1;
          end
          frames_due.push_back(f);
        end
        start_line();
      end
    end else begin
      pos = 32'(ln_count);
      if (ln_count != slcan_pkg::COUNT_MAX) ln_count = ln_count + 6'd1;
      if (pos == 0) begin
        case (c)
          slcan_pkg::CHAR_STD: ln_kind = slcan_pkg::KIND_STD;
          slcan_pkg::CHAR_EXT, slcan_pkg::CHAR_EXTX: ln_kind = slcan_pkg::KIND_EXT;
          slcan_pkg::CHAR_SRTR: ln_kind = slcan_pkg::KIND_STD_RTR;
          slcan_pkg::CHAR_ERTR: ln_kind = slcan_pkg::KIND_EXT_RTR;
          default: ln_kind = slcan_pkg::KIND_BAD;
        endcase
        ln_stop = 1'b0;
      end else if (ln_kind != slcan_pkg::KIND_BAD && ln_kind != slcan_pkg::KIND_NONE) begin
        if (pos <= idn) begin
          d = run_digit(c);
          if (d < 16) ln_id = {ln_id[27:0], d[3:0]};
        end else if (pos == idn + 1) begin
          if (c >= slcan_pkg::CHAR_ZERO && c <= slcan_pkg::CHAR_EIGHT) begin
            ln_dlc = 4'(c - slcan_pkg::CHAR_ZERO);
          end else begin
            ln_dlc = '0;
            ln_dlc_bad = 1'b1;
          end
        end else begin
          q = pos - (idn + 2);
          if (q < dn) begin
            sh = (q / 2) * 8;
            if (q % 2 == 0) ln_stop = 1'b0;
            d = run_digit(c);
            if (d < 16) ln_data[sh +: 8] = {ln_data[sh +: 4], d[3:0]};
          end else begin
            if (ln_tail == 0) ln_stop = 1'b0;
            if (ln_tail < slcan_pkg::STAMP_DIGITS) begin
              d = run_digit(c);
              if (d < 16) ln_stamp = {ln_stamp[11:0], d[3:0]};
            end
            if (ln_tail < slcan_pkg::TAIL_MAX) ln_tail = ln_tail + 3'd1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : drive_rx
    logic       take, nxt_v;
    logic [7:0] nxt_b;
    if (rst) begin
      rx_valid <= 1'b0;
      rx_byte <= 8'h00;
    end else begin
      take = rx_valid && rx_ready;
      if (take) parse_char(rx_byte);
      nxt_v = rx_valid && !take;
      nxt_b = rx_byte;
      if (!nxt_v && pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_v = 1'b1;
        nxt_b = pending.pop_front();
      end
      rx_valid <= nxt_v;
      rx_byte <= nxt_b;
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch_frames
    slcan_pkg::res_t got, want;
    int unsigned     hold_left;
    bit              hold_seen;
    if (rst) begin
      frame_ready <= 1'b0;
      hold_left = 0;
      hold_seen = 1'b0;
    end else begin
      if (frame_valid && frame_ready) begin
        got = {status, can_id, is_extended, is_remote, length_code, payload, stamp_ms,
               has_stamp};
        if (frames_due.size() == 0) begin
          $display("%0t unexpected frame beat: expected none actual %h", $time, got);
          errors++;
        end else begin
          want = frames_due.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("can_id", 64'(want.can_id), 64'(got.can_id));
          check_field("is_extended", 64'(want.is_extended), 64'(got.is_extended));
          check_field("is_remote", 64'(want.is_remote), 64'(got.is_remote));
          check_field("length_code", 64'(want.length_code), 64'(got.length_code));
          check_field("payload", want.payload, got.payload);
          check_field("stamp_ms", 64'(want.stamp_ms), 64'(got.stamp_ms));
          check_field("has_stamp", 64'(want.has_stamp), 64'(got.has_stamp));
        end
      end
      if (hold_want && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        frame_ready <= 1'b0;
      end else begin
        frame_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (rst || (rx_valid && rx_ready) || (frame_valid && frame_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic put(input logic [7:0] c);
    pending.push_back(c);
    queued_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(21);
    if (v < 10) return slcan_pkg::CHAR_ZERO + 8'(v);
    if (v < 16) return 8'("a") + 8'(v - 10);
    return 8'("A") + 8'(v - 16);
  endfunction

  function automatic logic [7:0] spoil(input logic [7:0] c, input int unsigned pct);
    if ($urandom_range(99) < pct) return 8'($urandom);
    return c;
  endfunction

  task automatic push_frame(input bit long_tail);
    logic [7:0]  ty;
    int unsigned sel, idn, dlc, nd, full;
    bit          remote;
    sel = $urandom_range(99);
    if (sel < 40) ty = slcan_pkg::CHAR_STD;
    else if (sel < 55) ty = slcan_pkg::CHAR_EXT;
    else if (sel < 65) ty = slcan_pkg::CHAR_EXTX;
    else if (sel < 78) ty = slcan_pkg::CHAR_SRTR;
    else if (sel < 92) ty = slcan_pkg::CHAR_ERTR;
    else ty = 8'($urandom);
    remote = (ty == slcan_pkg::CHAR_SRTR || ty == slcan_pkg::CHAR_ERTR);
    idn = (ty == slcan_pkg::CHAR_EXT || ty == slcan_pkg::CHAR_EXTX ||
           ty == slcan_pkg::CHAR_ERTR) ? 8 : 3;
    put(ty);
    repeat (idn) put(spoil(hex_char(), 4));
    nd = 0;
    if ($urandom_range(99) < 8) begin
      put(8'($urandom));
    end else begin
      dlc = $urandom_range(8);
      put(slcan_pkg::CHAR_ZERO + 8'(dlc));
      if (!remote) nd = 2 * dlc;
    end
    full = nd;
    if ($urandom_range(99) < 8) nd = $urandom_range(nd);
    repeat (nd) put(spoil(hex_char(), 4));
    if (nd != full) return;
    if (long_tail) begin
      repeat (60) put(spoil(hex_char(), 20));
    end else begin
      sel = $urandom_range(99);
      if (sel < 45) repeat (4) put(spoil(hex_char(), 5));
      else if (sel >= 80) repeat ($urandom_range(7, 1)) put(spoil(hex_char(), 30));
    end
  endtask

  task automatic push_random_line();
    if ($urandom_range(99) < 10) repeat ($urandom_range(12, 1)) put(8'($urandom));
    else push_frame($urandom_range(99) < 3);
    put($urandom_range(1) ? slcan_pkg::CHAR_CR : slcan_pkg::CHAR_LF);
    if ($urandom_range(99) < 10) put(slcan_pkg::CHAR_LF);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || rx_valid || frames_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_keep_remote(input logic v);
    @(posedge clk);
    keep_remote_we <= 1'b1;
    keep_remote_wdata <= v;
    keep_remote_cfg = v;
    @(posedge clk);
    keep_remote_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned sp[4] = '{0, 53, 0, 15};
    int unsigned rp[4] = '{0, 0, 53, 15};
    logic        kp[4] = '{1'b1, 1'b0, 1'b1, 1'b0};
    start_line();
    keep_remote_cfg = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_text("t0000"); put(slcan_pkg::CHAR_CR);
    push_text("x1234567881122334455667788FfFf"); put(slcan_pkg::CHAR_LF);
    push_text("r7FF2"); put(slcan_pkg::CHAR_CR);
    put(slcan_pkg::CHAR_CR); put(slcan_pkg::CHAR_LF);
    push_text("q"); put(slcan_pkg::CHAR_CR);
    push_text("t12"); put(slcan_pkg::CHAR_CR);
    push_text("t1239"); put(slcan_pkg::CHAR_CR);
    push_text("t123211"); put(slcan_pkg::CHAR_CR);
    push_text("t1g31zz12345"); put(slcan_pkg::CHAR_LF);
    push_text("tFFF1"); put(8'hC1); put(8'hB0); push_text("1a2b"); put(slcan_pkg::CHAR_CR);
    drain();

    set_keep_remote(1'b1);
    push_text("R000000004"); put(slcan_pkg::CHAR_CR);
    push_text("r7FF0ABCD"); put(slcan_pkg::CHAR_LF);
    push_frame(1'b1); put(slcan_pkg::CHAR_CR);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_keep_remote(kp[p]);
      send_idle_pct = sp[p];
      recv_stall_pct = rp[p];
      queued_total = 0;
      while (queued_total < 90) push_random_line();
      drain();
    end

    // hold the frame side while bytes keep coming
    set_keep_remote(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_want = 1'b1;
    queued_total = 0;
    while (queued_total < 75) push_random_line();
    drain();

    if (errors == 0 && frames_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
